// ===== design/vgrt_pkg.sv =====
// Shared types, constants and helpers for the voxel grid ray walker.
package vgrt_pkg;

  localparam int ORG_W  = 21;
  localparam int HD_W   = 16;
  localparam int CELL_W = 14;
  localparam int T_W    = 33;
  localparam int DIV_NW = 38;
  localparam int DIV_DW = 16;

  localparam logic [T_W-1:0] T_INF = 33'h1_0000_0000;
  localparam logic [31:0]    T_SAT = 32'hFFFF_FFFF;
  localparam logic signed [27:0] POS_MAX = 28'sd2097151;

  localparam logic [1:0] REG_EDGE_LEN  = 2'd0;
  localparam logic [1:0] REG_EXTENT_X  = 2'd1;
  localparam logic [1:0] REG_EXTENT_Y  = 2'd2;
  localparam logic [1:0] REG_EXTENT_Z  = 2'd3;

  // One queued command: a voxel write, or a cast with its walk set up.
  typedef struct packed {
    logic                          cast;
    logic [4:0]                    vx;
    logic [4:0]                    vy;
    logic [4:0]                    vz;
    logic                          occ;
    logic [2:0][ORG_W-1:0]         org;
    logic [2:0][HD_W-1:0]          hd;
    logic [2:0][CELL_W-1:0]        vox;
    logic [2:0][T_W-1:0]           tmax;
    logic [2:0][31:0]              tdel;
  } cmd_t;

  function automatic logic [HD_W-1:0] abs16(input logic [HD_W-1:0] h);
    return h[HD_W-1] ? (~h + 16'd1) : h;
  endfunction

  function automatic logic [31:0] sat32(input logic [DIV_NW-1:0] q);
    return (|q[DIV_NW-1:32]) ? T_SAT : q[31:0];
  endfunction

endpackage

// ===== design/vgrt_div.sv =====
// Serial restoring divider, two quotient bits per cycle.
module vgrt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vgrt_pkg::DIV_NW-1:0] dividend,
  input  logic [vgrt_pkg::DIV_DW-1:0] divisor,
  output logic                       done,
  output logic [vgrt_pkg::DIV_NW-1:0] quot,
  output logic [vgrt_pkg::DIV_DW-1:0] rem
);
  import vgrt_pkg::*;

  localparam int STEPS = DIV_NW / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rmd;
  logic [DIV_NW-1:0] q_next;
  logic [DIV_DW-1:0] r_next;

  always_comb begin
    logic [DIV_DW:0] trial;
    q_next = quo;
    r_next = rmd;
    for (int i = 0; i < 2; i++) begin
      trial  = {r_next, q_next[DIV_NW-1]};
      q_next = {q_next[DIV_NW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        r_next    = DIV_DW'(trial - {1'b0, divisor});
        q_next[0] = 1'b1;
      end else begin
        r_next = trial[DIV_DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rmd  <= '0;
        cnt  <= CW'(STEPS);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= q_next;
        rmd <= r_next;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = quo;
  assign rem  = rmd;

endmodule

// ===== design/vgrt_front.sv =====
// Front end: takes items, sets up start cell and boundary t for casts.
module vgrt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [4:0]          voxel_x,
  input  logic [4:0]          voxel_y,
  input  logic [4:0]          voxel_z,
  input  logic                occupied,
  input  logic [20:0]         origin_x,
  input  logic [20:0]         origin_y,
  input  logic [20:0]         origin_z,
  input  logic signed [15:0]  heading_x,
  input  logic signed [15:0]  heading_y,
  input  logic signed [15:0]  heading_z,
  input  logic [7:0]          edge_len_eff,
  input  logic                hold,
  output logic                push,
  output vgrt_pkg::cmd_t      push_cmd,
  input  logic                full
);
  import vgrt_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_CELL, F_TMAX, F_TDEL, F_PUSH} fstate_t;

  fstate_t           state;
  logic [1:0]        ax;
  logic              div_start;
  cmd_t              cmd;
  logic [15:0]       num;

  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  logic              div_done;
  logic [DIV_NW-1:0] div_quot;
  logic [DIV_DW-1:0] div_rem;
  logic [HD_W-1:0]   h;
  logic [15:0]       r_full;
  logic [15:0]       cell_edge;
  logic [15:0]       num_c;

  vgrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    h         = cmd.hd[ax];
    cell_edge = {edge_len_eff, 8'd0};
    r_full    = {div_rem[7:0], cmd.org[ax][7:0]};
    num_c     = h[HD_W-1] ? r_full : 16'(cell_edge - r_full);
    unique case (state)
      F_CELL: begin
        div_dividend = {25'd0, cmd.org[ax][20:8]};
        div_divisor  = {8'd0, edge_len_eff};
      end
      F_TMAX: begin
        div_dividend = {num, 22'd0};
        div_divisor  = abs16(h);
      end
      F_TDEL: begin
        div_dividend = {edge_len_eff, 30'd0};
        div_divisor  = abs16(h);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = abs16(h);
      end
    endcase
  end

  assign in_ready = (state == F_IDLE) && !hold;
  assign push     = (state == F_PUSH) && !full;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      ax        <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            cmd.cast <= kind;
            cmd.vx   <= voxel_x;
            cmd.vy   <= voxel_y;
            cmd.vz   <= voxel_z;
            cmd.occ  <= occupied;
            cmd.org  <= {origin_z, origin_y, origin_x};
            cmd.hd   <= {heading_z, heading_y, heading_x};
            ax       <= '0;
            if (kind) begin
              state     <= F_CELL;
              div_start <= 1'b1;
            end else begin
              state <= F_PUSH;
            end
          end
        end
        F_CELL: begin
          if (div_done) begin
            cmd.vox[ax] <= {1'b0, div_quot[12:0]};
            num         <= num_c;
            if (h == '0) begin
              // zero heading: axis never taken
              cmd.tmax[ax] <= T_INF;
              cmd.tdel[ax] <= '0;
              if (ax == 2'd2) begin
                state <= F_PUSH;
              end else begin
                ax        <= ax + 1'b1;
                div_start <= 1'b1;
              end
            end else begin
              state     <= F_TMAX;
              div_start <= 1'b1;
            end
          end
        end
        F_TMAX: begin
          if (div_done) begin
            cmd.tmax[ax] <= {1'b0, sat32(div_quot)};
            state        <= F_TDEL;
            div_start    <= 1'b1;
          end
        end
        F_TDEL: begin
          if (div_done) begin
            cmd.tdel[ax] <= sat32(div_quot);
            if (ax == 2'd2) begin
              state <= F_PUSH;
            end else begin
              ax        <= ax + 1'b1;
              state     <= F_CELL;
              div_start <= 1'b1;
            end
          end
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== design/vgrt_fifo.sv =====
// Two-entry command queue between front and back.
module vgrt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vgrt_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output vgrt_pkg::cmd_t head
);
  import vgrt_pkg::*;

  cmd_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (do_push) begin
        slots[wp] <= push_cmd;
        wp        <= ~wp;
      end
      if (do_pop) rp <= ~rp;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== design/vgrt_back.sv =====
// Back end: occupancy map, voxel writes, DDA walk and hit point.
module vgrt_back #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  vgrt_pkg::cmd_t q_cmd,
  output logic           q_pop,
  input  logic [5:0]     ext_x,
  input  logic [5:0]     ext_y,
  input  logic [5:0]     ext_z,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           hit,
  output logic [20:0]    hit_pos_x,
  output logic [20:0]    hit_pos_y,
  output logic [20:0]    hit_pos_z
);
  import vgrt_pkg::*;

  localparam int MAP_DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam logic [8:0] GX = 9'(GRID_X);
  localparam logic [8:0] GY = 9'(GRID_Y);
  localparam logic [8:0] GZ = 9'(GRID_Z);

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_START, B_WALK, B_PROBE, B_MUL, B_ADD, B_DONE
  } bstate_t;

  bstate_t                state;
  logic [AW-1:0]          clr_addr;
  logic [2:0][CELL_W-1:0] vox;
  logic [2:0][T_W-1:0]    tmax;
  logic [2:0][31:0]       tdel;
  logic [2:0][ORG_W-1:0]  org;
  logic [2:0][HD_W-1:0]   hd;
  logic [31:0]            tcur;
  logic [1:0]             ax_cnt;
  logic [47:0]            prod;
  logic [2:0][20:0]       pos;
  logic                   hit_r;
  logic                   rd_bit;

  logic                   mem [MAP_DEPTH];
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic                   mem_wd;

  logic [2:0][8:0]        ext_c;
  logic [1:0]             sel;
  logic [T_W-1:0]         tcur_c;
  logic [T_W-1:0]         tsum;
  logic [T_W-1:0]         tnext;
  logic [2:0][CELL_W-1:0] vox_next;
  logic                   in_now;
  logic                   in_new;
  logic [23:0]            addr_new;
  logic [23:0]            addr_wr;
  logic                   wr_in_range;
  logic [25:0]            off;
  logic signed [27:0]     p_c;
  logic [20:0]            p_clamped;

  function automatic logic in_grid(input logic [2:0][CELL_W-1:0] c,
                                   input logic [2:0][8:0] e);
    logic ok;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (c[a][CELL_W-1] || (c[a][CELL_W-2:0] >= {4'd0, e[a]})) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [23:0] map_addr(input logic [7:0] x, input logic [7:0] y,
                                           input logic [7:0] z);
    logic [31:0] s;
    s = (32'(x) * 32'(GRID_Y) + 32'(y)) * 32'(GRID_Z) + 32'(z);
    return s[23:0];
  endfunction

  always_comb begin
    ext_c[0] = ({3'd0, ext_x} > GX) ? GX : {3'd0, ext_x};
    ext_c[1] = ({3'd0, ext_y} > GY) ? GY : {3'd0, ext_y};
    ext_c[2] = ({3'd0, ext_z} > GZ) ? GZ : {3'd0, ext_z};

    // strict compares: ties go to z, then y
    if (tmax[0] < tmax[1]) sel = (tmax[0] < tmax[2]) ? 2'd0 : 2'd2;
    else                   sel = (tmax[1] < tmax[2]) ? 2'd1 : 2'd2;
    tcur_c = tmax[sel];
    tsum   = {1'b0, tmax[sel][31:0]} + {1'b0, tdel[sel]};
    tnext  = tsum[T_W-1] ? {1'b0, T_SAT} : tsum;

    vox_next      = vox;
    vox_next[sel] = hd[sel][HD_W-1] ? vox[sel] - 1'b1 : vox[sel] + 1'b1;
    in_now        = in_grid(vox, ext_c);
    in_new        = in_grid(vox_next, ext_c);
    addr_new      = map_addr(vox_next[0][7:0], vox_next[1][7:0], vox_next[2][7:0]);

    addr_wr     = map_addr({3'd0, q_cmd.vx}, {3'd0, q_cmd.vy}, {3'd0, q_cmd.vz});
    wr_in_range = ({4'd0, q_cmd.vx} < GX) && ({4'd0, q_cmd.vy} < GY) &&
                  ({4'd0, q_cmd.vz} < GZ);

    off = prod[47:22];
    if (hd[ax_cnt][HD_W-1]) p_c = $signed({7'd0, org[ax_cnt]}) - $signed({2'd0, off});
    else                    p_c = $signed({7'd0, org[ax_cnt]}) + $signed({2'd0, off});
    if (p_c[27])            p_clamped = '0;
    else if (p_c > POS_MAX) p_clamped = POS_MAX[20:0];
    else                    p_clamped = p_c[20:0];

    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = 1'b0;
    if (state == B_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == B_IDLE && q_valid && !q_cmd.cast && wr_in_range) begin
      mem_we = 1'b1;
      mem_wa = addr_wr[AW-1:0];
      mem_wd = q_cmd.occ;
    end
  end

  assign q_pop    = (state == B_IDLE) && q_valid;
  assign clearing = (state == B_CLEAR);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_bit <= mem[addr_new[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      ax_cnt    <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAP_DEPTH - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (q_valid && q_cmd.cast) begin
            vox   <= q_cmd.vox;
            tmax  <= q_cmd.tmax;
            tdel  <= q_cmd.tdel;
            org   <= q_cmd.org;
            hd    <= q_cmd.hd;
            state <= B_START;
          end
        end
        B_START: begin
          hit_r <= 1'b0;
          state <= in_now ? B_WALK : B_DONE;
        end
        B_WALK: begin
          if (tcur_c[T_W-1]) begin
            state <= B_DONE;
          end else begin
            tcur      <= tcur_c[31:0];
            tmax[sel] <= tnext;
            vox       <= vox_next;
            state     <= in_new ? B_PROBE : B_DONE;
          end
        end
        B_PROBE: begin
          if (rd_bit) begin
            hit_r  <= 1'b1;
            ax_cnt <= '0;
            state  <= B_MUL;
          end else begin
            state <= B_WALK;
          end
        end
        B_MUL: begin
          prod  <= 48'(tcur) * 48'(abs16(hd[ax_cnt]));
          state <= B_ADD;
        end
        B_ADD: begin
          pos[ax_cnt] <= p_clamped;
          if (ax_cnt == 2'd2) begin
            state <= B_DONE;
          end else begin
            ax_cnt <= ax_cnt + 1'b1;
            state  <= B_MUL;
          end
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            hit       <= hit_r;
            hit_pos_x <= hit_r ? pos[0] : '0;
            hit_pos_y <= hit_r ? pos[1] : '0;
            hit_pos_z <= hit_r ? pos[2] : '0;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== design/voxel_grid_ray_traversal.sv =====
// Voxel occupancy map with 3D DDA ray walker: front setup, queue, back walk.
// Write item: front F_IDLE then F_PUSH; the back writes the map bit in B_IDLE.
// Cast item: setup takes up to 9 divisions in the one shared divider; the walk passes
// B_WALK and B_PROBE per voxel step (one map read each), then B_MUL and B_ADD for each
// axis give the hit point and B_DONE loads the result register.
// The front sets up the next cast while the back walks the current one.
// Reset: a clearing pass over all GRID_X*GRID_Y*GRID_Z map entries (32768 by default), in_ready low.
module voxel_grid_ray_traversal #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [4:0]         voxel_x,
  input  logic [4:0]         voxel_y,
  input  logic [4:0]         voxel_z,
  input  logic               occupied,
  input  logic [20:0]        origin_x,
  input  logic [20:0]        origin_y,
  input  logic [20:0]        origin_z,
  input  logic signed [15:0] heading_x,
  input  logic signed [15:0] heading_y,
  input  logic signed [15:0] heading_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [20:0]        hit_pos_x,
  output logic [20:0]        hit_pos_y,
  output logic [20:0]        hit_pos_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import vgrt_pkg::*;

  logic [7:0] edge_len;
  logic [5:0] grid_extent_x;
  logic [5:0] grid_extent_y;
  logic [5:0] grid_extent_z;
  logic [7:0] edge_len_eff;

  logic       q_push;
  cmd_t       q_push_cmd;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  cmd_t       q_head;
  logic       clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_len      <= 8'd1;
      grid_extent_x <= 6'd32;
      grid_extent_y <= 6'd32;
      grid_extent_z <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EDGE_LEN: edge_len      <= cfg_data;
        REG_EXTENT_X: grid_extent_x <= cfg_data[5:0];
        REG_EXTENT_Y: grid_extent_y <= cfg_data[5:0];
        REG_EXTENT_Z: grid_extent_z <= cfg_data[5:0];
        default:      edge_len      <= edge_len;
      endcase
    end
  end

  assign edge_len_eff = (edge_len == 8'd0) ? 8'd1 : edge_len;

  vgrt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .voxel_x      (voxel_x),
    .voxel_y      (voxel_y),
    .voxel_z      (voxel_z),
    .occupied     (occupied),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .origin_z     (origin_z),
    .heading_x    (heading_x),
    .heading_y    (heading_y),
    .heading_z    (heading_z),
    .edge_len_eff (edge_len_eff),
    .hold         (clearing),
    .push         (q_push),
    .push_cmd     (q_push_cmd),
    .full         (q_full)
  );

  vgrt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  vgrt_back #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_head),
    .q_pop     (q_pop),
    .ext_x     (grid_extent_x),
    .ext_y     (grid_extent_y),
    .ext_z     (grid_extent_z),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .hit_pos_x (hit_pos_x),
    .hit_pos_y (hit_pos_y),
    .hit_pos_z (hit_pos_z)
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_pos_x == '0 && hit_pos_y == '0 && hit_pos_z == '0)
    else $error("miss result with nonzero hit point");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("item accepted during map clear");

  a_queue_empty_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_valid)
    else $error("queued item during map clear");

endmodule
